FILE: rtl/modular_power_tower_top_macros.svh
// Assertion helpers for the modular power block.
`ifndef MODULAR_POWER_TOWER_TOP_MACROS_SVH
`define MODULAR_POWER_TOWER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular power tower: assertion failed");

// Next-cycle implication, disabled in reset.
`define MPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular power tower: assertion failed");

`endif

FILE: rtl/mpt_pkg.sv
package mpt_pkg;

  localparam int W     = 31;
  localparam int CNT_W = $clog2(W + 1);

  localparam logic [W-1:0] MOD_RESET = W'(1000000007);
  localparam logic [W-1:0] MOD_MIN   = W'(3);
  localparam logic [W-1:0] ONE       = W'(1);

  typedef enum logic [1:0] {
    OP_RED,
    OP_ACC,
    OP_SQ
  } mul_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_W,
    S_CHK,
    S_ACC_W,
    S_SQ_W,
    S_FIN
  } st_t;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_t op;
    logic    exp_shift;
    logic    outer;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_bit0;
    logic tower;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/mpt_mulmod.sv
module mpt_mulmod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [mpt_pkg::W-1:0] a,
  input  logic [mpt_pkg::W-1:0] b,
  input  logic [mpt_pkg::W-1:0] m,
  output logic                  done,
  output logic [mpt_pkg::W-1:0] res
);

  logic [mpt_pkg::W-1:0]     acc_r, a_r, b_r;
  logic [mpt_pkg::CNT_W-1:0] cnt_r;
  logic                      done_r;
  logic [mpt_pkg::W:0]       t, t1, u, u1;

  // One bit of b per cycle, MSB first: acc = 2*acc + bit*a, mod m.
  always_comb begin
    t  = {acc_r, 1'b0};
    t1 = (t >= {1'b0, m}) ? t - {1'b0, m} : t;
    u  = t1 + (b_r[mpt_pkg::W-1] ? {1'b0, a_r} : '0);
    u1 = (u >= {1'b0, m}) ? u - {1'b0, m} : u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= mpt_pkg::CNT_W'(mpt_pkg::W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mpt_pkg::CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (cnt_r != '0) begin
      acc_r <= u1[mpt_pkg::W-1:0];
      b_r   <= {b_r[mpt_pkg::W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

FILE: rtl/mpt_dp.sv
module mpt_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mpt_pkg::cmd_t         cmd,
  output mpt_pkg::sts_t         sts,
  input  logic                  in_action,
  input  logic [mpt_pkg::W-1:0] in_base,
  input  logic [mpt_pkg::W-1:0] in_exponent,
  input  logic                  cfg_we,
  input  logic [mpt_pkg::W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [mpt_pkg::W-1:0] out_residue
);

  logic [mpt_pkg::W-1:0] mod_r, m_r, acc_r, sq_r, exp_r, base_r, res_r;
  logic                  tower_r, out_valid_r;
  mpt_pkg::mul_op_t      op_r;
  logic [mpt_pkg::W-1:0] eff, mul_a, mul_b, mul_res;
  logic                  mul_done;

  assign eff = (mod_r < mpt_pkg::MOD_MIN) ? mpt_pkg::MOD_MIN : mod_r;

  always_comb begin
    unique case (cmd.op)
      mpt_pkg::OP_RED: begin
        mul_a = mpt_pkg::ONE;
        mul_b = base_r;
      end
      mpt_pkg::OP_ACC: begin
        mul_a = acc_r;
        mul_b = sq_r;
      end
      default: begin
        mul_a = sq_r;
        mul_b = sq_r;
      end
    endcase
  end

  mpt_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (m_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= mpt_pkg::MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mod_r <= cfg_wdata;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r  <= in_base;
      tower_r <= in_action;
      m_r     <= in_action ? eff - mpt_pkg::ONE : eff;
      exp_r   <= in_action ? in_base : in_exponent;
      acc_r   <= mpt_pkg::ONE;
    end else if (cmd.outer) begin
      // inner power becomes the exponent of the outer one
      m_r     <= eff;
      exp_r   <= acc_r;
      acc_r   <= mpt_pkg::ONE;
      tower_r <= 1'b0;
    end else begin
      if (cmd.exp_shift) exp_r <= exp_r >> 1;
      if (mul_done) begin
        if (op_r == mpt_pkg::OP_ACC) acc_r <= mul_res;
        else sq_r <= mul_res;
      end
    end
    if (cmd.mul_start) op_r <= cmd.op;
    if (cmd.out_load) res_r <= acc_r;
  end

  assign sts.mul_done = mul_done;
  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_bit0 = exp_r[0];
  assign sts.tower    = tower_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_residue = res_r;

endmodule

FILE: rtl/mpt_ctrl.sv
module mpt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mpt_pkg::sts_t sts,
  output mpt_pkg::cmd_t cmd
);

  mpt_pkg::st_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= mpt_pkg::S_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    cmd.op   = mpt_pkg::OP_RED;
    in_stall = (st_r != mpt_pkg::S_IDLE);
    unique case (st_r)
      mpt_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt   = mpt_pkg::S_RED_GO;
        end
      end
      mpt_pkg::S_RED_GO: begin
        cmd.mul_start = 1'b1;
        st_nxt        = mpt_pkg::S_RED_W;
      end
      mpt_pkg::S_RED_W: begin
        if (sts.mul_done) st_nxt = mpt_pkg::S_CHK;
      end
      mpt_pkg::S_CHK: begin
        priority if (sts.exp_zero) begin
          st_nxt = mpt_pkg::S_FIN;
        end else if (sts.exp_bit0) begin
          cmd.mul_start = 1'b1;
          cmd.op        = mpt_pkg::OP_ACC;
          st_nxt        = mpt_pkg::S_ACC_W;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = mpt_pkg::OP_SQ;
          st_nxt        = mpt_pkg::S_SQ_W;
        end
      end
      mpt_pkg::S_ACC_W: begin
        // square only reads sq, so start it as the multiply lands
        cmd.op = mpt_pkg::OP_SQ;
        if (sts.mul_done) begin
          cmd.mul_start = 1'b1;
          st_nxt        = mpt_pkg::S_SQ_W;
        end
      end
      mpt_pkg::S_SQ_W: begin
        if (sts.mul_done) begin
          cmd.exp_shift = 1'b1;
          st_nxt        = mpt_pkg::S_CHK;
        end
      end
      mpt_pkg::S_FIN: begin
        priority if (sts.tower) begin
          cmd.outer = 1'b1;
          st_nxt    = mpt_pkg::S_RED_GO;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = mpt_pkg::S_IDLE;
        end
      end
      default: st_nxt = mpt_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/modular_power_tower_top.sv
// Each exponentiation loads its operands, reduces the base, then squares for every exponent
// bit and multiplies for each set bit; a tower item runs two of them. One item at a time:
// the shared bit-serial modular multiplier (W = 31 bits), one operand bit per cycle, does
// every step. A finished beat waits in the output register while the next item is taken.
// Reset (synchronous, active low): modulus back to 1000000007, control idle.
module modular_power_tower_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [mpt_pkg::W-1:0] in_base,
  input  logic [mpt_pkg::W-1:0] in_exponent,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [mpt_pkg::W-1:0] out_residue,
  input  logic                  cfg_we,
  input  logic [mpt_pkg::W-1:0] cfg_wdata
);

  mpt_pkg::cmd_t cmd;
  mpt_pkg::sts_t sts;

  mpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (in_action),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_residue (out_residue)
  );

endmodule

FILE: rtl/mpt_checker.sv
`include "modular_power_tower_top_macros.svh"

module mpt_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [mpt_pkg::W-1:0] out_residue
);

  // one item in flight: an accepted beat closes the input
  `MPT_ASSERT_NXT(a_accept_closes, in_valid && !in_stall, in_stall)
  // a new result lands as the input reopens
  `MPT_ASSERT_IMP(a_result_reopens, $rose(out_valid), !in_stall)
  // hold a stalled result beat
  `MPT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_residue))

endmodule

bind modular_power_tower_top mpt_checker u_mpt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_residue (out_residue)
);

FILE: test/tb_modular_power_tower_top.sv
module tb_modular_power_tower_top;

  localparam int W = mpt_pkg::W;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic ACT_PLAIN = 1'b0;
  localparam logic ACT_TOWER = 1'b1;

  typedef struct packed {
    logic         action;
    logic [W-1:0] base;
    logic [W-1:0] exponent;
  } power_req_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_action;
  logic [W-1:0] in_base;
  logic [W-1:0] in_exponent;
  logic out_valid;
  logic out_stall;
  logic [W-1:0] out_residue;
  logic cfg_we;
  logic [W-1:0] cfg_wdata;

  modular_power_tower_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_base(in_base), .in_exponent(in_exponent),
    .out_valid(out_valid), .out_stall(out_stall), .out_residue(out_residue),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  power_req_t pending_reqs[$];
  logic [W-1:0] residue_q[$];
  logic [W-1:0] modulus_reg;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int idle_count;
  int fail_count;

  function automatic logic [62:0] pow_mod(logic [62:0] b, logic [62:0] e, logic [62:0] m);
    logic [62:0] acc;
    logic [62:0] sq;
    acc = 63'(1);
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e = e >> 1;
    end
    return acc % m;
  endfunction

  function automatic logic [W-1:0] predict_residue(power_req_t r, logic [W-1:0] mreg);
    logic [62:0] m;
    logic [62:0] inner;
    m = (mreg < mpt_pkg::MOD_MIN) ? 63'(mpt_pkg::MOD_MIN) : 63'(mreg);
    if (r.action == ACT_TOWER) begin
      inner = pow_mod(63'(r.base), 63'(r.base), m - 1);
      return W'(pow_mod(63'(r.base), inner, m));
    end
    return W'(pow_mod(63'(r.base), 63'(r.exponent), m));
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        residue_q = {residue_q,
                     predict_residue({in_action, in_base, in_exponent}, modulus_reg)};
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          power_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_action <= r.action;
          in_base <= r.base;
          in_exponent <= r.exponent;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (residue_q.size() == 0) begin
        $error("unexpected beat: residue %0d", out_residue);
        fail_count++;
      end else begin
        logic [W-1:0] want;
        want = residue_q.pop_front();
        if (out_residue !== want) begin
          $error("residue mismatch: expected %0d actual %0d", want, out_residue);
          fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [W-1:0] rand_bits();
    logic [W-1:0] v;
    case ($urandom_range(3))
      0: v = W'($urandom_range(20));
      1: v = W'($urandom) >> $urandom_range(30);
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_req(logic a, logic [W-1:0] b, logic [W-1:0] e);
    power_req_t r;
    r = '{action: a, base: b, exponent: e};
    pending_reqs = {pending_reqs, r};
  endtask

  // sample after the edge so pending updates have settled
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || residue_q.size() > 0) @(negedge clk);
    repeat (5000) @(posedge clk);
  endtask

  task automatic write_modulus(logic [W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    modulus_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) queue_req(1'($urandom_range(1)), rand_bits(), rand_bits());
    drain();
  endtask

  initial begin
    logic [W-1:0] all_ones;
    all_ones = '1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_base = '0;
    in_exponent = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    fail_count = 0;
    modulus_reg = mpt_pkg::MOD_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset modulus
    queue_req(ACT_PLAIN, W'(0), W'(0));
    queue_req(ACT_TOWER, W'(0), W'(0));
    queue_req(ACT_PLAIN, all_ones, all_ones);
    queue_req(ACT_TOWER, all_ones, W'(0));
    queue_req(ACT_PLAIN, W'(1000000007), W'(5));
    queue_req(ACT_PLAIN, W'(1000000008), all_ones);
    queue_req(ACT_TOWER, W'(2), W'(0));
    queue_req(ACT_PLAIN, W'(12345), W'(1));
    queue_req(ACT_PLAIN, W'(0), W'(7));
    drain();
    // small modulus values clamp to three
    write_modulus(W'(0));
    queue_req(ACT_TOWER, W'(5), W'(0));
    queue_req(ACT_PLAIN, W'(5), W'(3));
    drain();
    write_modulus(W'(2));
    queue_req(ACT_TOWER, all_ones, W'(1));
    queue_req(ACT_PLAIN, W'(2), W'(2));
    drain();
    write_modulus(all_ones);
    queue_req(ACT_TOWER, all_ones - W'(1), W'(0));
    queue_req(ACT_PLAIN, all_ones, W'(9));
    queue_req(ACT_PLAIN, all_ones - W'(1), all_ones);
    drain();

    write_modulus(W'(3));
    random_phase(12, 0, 0);
    write_modulus(W'($urandom));
    random_phase(20, 73, 0);
    write_modulus(W'(1000000007));
    random_phase(20, 0, 73);
    write_modulus(W'($urandom_range(1000, 3)));
    random_phase(20, 34, 34);

    // long receiver hold so the block backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) queue_req(1'($urandom_range(1)), rand_bits(), W'($urandom_range(255)));
    hold_cycles = 20000;
    drain();
    write_modulus(all_ones);
    random_phase(20, 0, 0);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
